// ===== rtl/bae_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types for the block arithmetic encoder.
// No dependencies; all other files use it by scoped names.
package bae_pkg;

  localparam int FRAC_BITS_DEF = 32;
  localparam int ALPHABET_DEF  = 256;
  localparam int MAX_BLOCK_DEF = 8;

  localparam int SYM_W       = 8;
  localparam int BOUND_W     = 33;
  localparam int BLEN_W      = 4;
  localparam int BLOCK_RESET = 5;
  localparam int BYTE_W      = 8;

  localparam int DIG_BITS = 8;
  localparam int N_DIG    = (BOUND_W + DIG_BITS - 1) / DIG_BITS;

  localparam int SEARCH_CAP = 40;
  localparam int CODE_W     = 40;
  localparam int STEP_W     = 6;
  localparam int NB_W       = 3;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_CODE = 1'b1
  } cmd_t;

  typedef enum logic {
    KIND_COUNT = 1'b0,
    KIND_BYTE  = 1'b1
  } kind_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              error;
  } result_t;

endpackage

// ===== rtl/bae_in_if.sv =====
`timescale 1ns / 1ps
// Request channel of the encoder: valid/ready plus one load or symbol request.
// Depends on bae_pkg for field widths.
interface bae_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [bae_pkg::SYM_W-1:0]    symbol;
  logic [bae_pkg::BOUND_W-1:0]  lower_bound;
  logic [bae_pkg::BOUND_W-1:0]  upper_bound;
  logic                         end_of_text;

  modport source (output valid, cmd, symbol, lower_bound, upper_bound, end_of_text,
                  input ready);
  modport sink   (input valid, cmd, symbol, lower_bound, upper_bound, end_of_text,
                  output ready);
endinterface

// ===== rtl/bae_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the encoder: valid/ready plus one count or code byte.
// Depends on bae_pkg for field widths.
interface bae_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [bae_pkg::BYTE_W-1:0]  value;
  logic                        last;
  logic                        error;

  modport source (output valid, kind, value, last, error, input ready);
  modport sink   (input valid, kind, value, last, error, output ready);
endinterface

// ===== rtl/block_arithmetic_encoder.sv =====
`timescale 1ns / 1ps
// Block arithmetic encoder: range table, interval narrowing and code search.
// Depends on bae_pkg, bae_in_if, bae_out_if and bae_mul.
//
//   channel  dir  handshake      payload
//   item     in   valid/ready    cmd, symbol, lower_bound, upper_bound, end_of_text
//   result   out  valid/ready    kind, value, last, error
//   cfg      in   cfg_we         cfg_wdata (block_length)
//
// A load is written to the range table when accepted. A symbol steps through READ,
// MUL_LO, MUL_HI and CHECK, using the shared digit-serial multiplier twice per symbol.
// A closing symbol then searches, up to min(FRAC_BITS, 40) steps, and emits
// one result per cycle while the result side is not stalled.
// Reset (rst, synchronous) restores the interval [0,1), block_length 5; the
// range table holds garbage until loaded. A stalled result holds in the output
// register; a new request is taken while the last result of a block still waits.
module block_arithmetic_encoder #(
  parameter int FRAC_BITS     = bae_pkg::FRAC_BITS_DEF,
  parameter int ALPHABET_SIZE = bae_pkg::ALPHABET_DEF,
  parameter int MAX_BLOCK     = bae_pkg::MAX_BLOCK_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  bae_in_if.sink                      item,
  bae_out_if.source                   result,
  input  logic                        cfg_we,
  input  logic [bae_pkg::BLEN_W-1:0]  cfg_wdata
);

  localparam int WW         = FRAC_BITS + 1;
  localparam int AW         = $clog2(ALPHABET_SIZE);
  localparam int BW         = bae_pkg::BOUND_W;
  localparam int CW         = (WW > BW) ? WW : BW;
  localparam int SEARCH_MAX = (FRAC_BITS < bae_pkg::SEARCH_CAP) ? FRAC_BITS
                                                                 : bae_pkg::SEARCH_CAP;
  localparam int CODE_W     = bae_pkg::CODE_W;
  localparam int STEP_W     = bae_pkg::STEP_W;
  localparam int NB_W       = bae_pkg::NB_W;
  localparam int BLEN_W     = bae_pkg::BLEN_W;
  localparam int BYTE_W     = bae_pkg::BYTE_W;
  localparam logic [WW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CW-1:0] ONE_C = CW'(ONE_Q);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_READ      = 9'b000000010,
    S_MUL_LO    = 9'b000000100,
    S_MUL_HI    = 9'b000001000,
    S_CHECK     = 9'b000010000,
    S_SEARCH    = 9'b000100000,
    S_EMIT_CNT  = 9'b001000000,
    S_EMIT_BYTE = 9'b010000000,
    S_ABORT     = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [2*BW-1:0]      range_mem [ALPHABET_SIZE];
  logic [2*BW-1:0]      rd_word;
  logic [BW-1:0]        rd_lo, rd_hi;
  logic [BW-1:0]        lo_sat, hi_sat;

  logic [WW-1:0]        left, right, nl, nr;
  logic [WW-1:0]        tmp, wt, cand;
  logic [BLEN_W-1:0]    block_count, block_length, limit, count_inc;
  logic                 eot_q;
  logic [STEP_W-1:0]    step;
  logic [CODE_W-1:0]    code_sr;
  logic [FRAC_BITS+CODE_W-1:0] code_ext;
  logic [NB_W-1:0]      bytes_left;

  logic                 in_acc, sym_ok, mem_we, mem_re;
  logic                 take, hit, close, restart;
  logic                 out_free, out_load;
  bae_pkg::result_t     out_q, out_n;

  logic                 mul_start, mul_done;
  logic [BW-1:0]        mul_b;
  logic [WW-1:0]        mul_p;

  assign item.ready = (state == S_IDLE);
  assign in_acc     = item.valid && item.ready;
  assign sym_ok     = ({1'b0, item.symbol} < (bae_pkg::SYM_W + 1)'(ALPHABET_SIZE));
  assign mem_we     = in_acc && (item.cmd == bae_pkg::CMD_LOAD) && sym_ok;
  assign mem_re     = in_acc && (item.cmd == bae_pkg::CMD_CODE);

  assign lo_sat = (CW'(item.lower_bound) > ONE_C) ? BW'(ONE_C) : item.lower_bound;
  assign hi_sat = (CW'(item.upper_bound) > ONE_C) ? BW'(ONE_C) : item.upper_bound;
  assign rd_lo  = rd_word[BW-1:0];
  assign rd_hi  = rd_word[2*BW-1:BW];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      range_mem[item.symbol[AW-1:0]] <= {hi_sat, lo_sat};
    end
    if (mem_re) begin
      rd_word <= range_mem[item.symbol[AW-1:0]];
    end
  end

  bae_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (right - left),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign limit = (block_length == '0) ? BLEN_W'(1) :
                 (block_length > BLEN_W'(MAX_BLOCK)) ? BLEN_W'(MAX_BLOCK) : block_length;
  assign count_inc = block_count + BLEN_W'(1);
  assign close     = eot_q || (count_inc >= limit);

  assign cand     = tmp + wt;
  assign take     = (cand < left);
  assign hit      = !take && (cand < right);
  assign code_ext = {cand[FRAC_BITS-1:0], CODE_W'(0)};

  assign out_free = !result.valid || result.ready;
  assign restart  = out_free && ((state == S_ABORT) ||
                    ((state == S_EMIT_BYTE) && (bytes_left == NB_W'(1))));

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_b      = rd_lo;
    out_load   = 1'b0;
    out_n      = '0;
    case (state)
      S_IDLE: begin
        if (in_acc && (item.cmd == bae_pkg::CMD_CODE)) begin
          state_next = sym_ok ? S_READ : S_ABORT;
        end
      end
      S_READ: begin
        mul_start  = 1'b1;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_b      = rd_hi;
          state_next = S_MUL_HI;
        end
      end
      S_MUL_HI: begin
        if (mul_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (nr <= nl) begin
          state_next = S_ABORT;
        end else if (close) begin
          state_next = S_SEARCH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_next = S_EMIT_CNT;
        end else if (step == STEP_W'(SEARCH_MAX)) begin
          state_next = S_ABORT;
        end
      end
      S_EMIT_CNT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_n.kind  = bae_pkg::KIND_COUNT;
          out_n.value = BYTE_W'(step);
          state_next  = S_EMIT_BYTE;
        end
      end
      S_EMIT_BYTE: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_n.kind  = bae_pkg::KIND_BYTE;
          out_n.value = code_sr[CODE_W-1 -: BYTE_W];
          out_n.last  = (bytes_left == NB_W'(1));
          if (bytes_left == NB_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      S_ABORT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_n.kind  = bae_pkg::KIND_COUNT;
          out_n.last  = 1'b1;
          out_n.error = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      left         <= '0;
      right        <= ONE_Q;
      block_count  <= '0;
      block_length <= BLEN_W'(bae_pkg::BLOCK_RESET);
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        block_length <= cfg_wdata;
      end
      if (out_load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (restart) begin
        left        <= '0;
        right       <= ONE_Q;
        block_count <= '0;
      end else if ((state == S_CHECK) && (nr > nl)) begin
        left        <= nl;
        right       <= nr;
        block_count <= count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q <= out_n;
    end
    if (mem_re) begin
      eot_q <= item.end_of_text;
    end
    if ((state == S_MUL_LO) && mul_done) begin
      nl <= left + mul_p;
    end
    if ((state == S_MUL_HI) && mul_done) begin
      nr <= left + mul_p;
    end
    if (state == S_CHECK) begin
      tmp  <= '0;
      wt   <= ONE_Q >> 1;
      step <= STEP_W'(1);
    end else if (state == S_SEARCH) begin
      if (hit) begin
        code_sr    <= code_ext[FRAC_BITS+CODE_W-1 -: CODE_W];
        bytes_left <= NB_W'((step + STEP_W'(7)) >> 3);
      end else begin
        if (take) begin
          tmp <= cand;
        end
        wt   <= wt >> 1;
        step <= step + STEP_W'(1);
      end
    end else if ((state == S_EMIT_BYTE) && out_free) begin
      code_sr    <= code_sr << BYTE_W;
      bytes_left <= bytes_left - NB_W'(1);
    end
  end

  assign result.kind  = out_q.kind;
  assign result.value = out_q.value;
  assign result.last  = out_q.last;
  assign result.error = out_q.error;

  a_interval_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (left < right))
    else $error("interval left not below right while idle");

  a_mul_done_owned: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> ((state == S_MUL_LO) || (state == S_MUL_HI)))
    else $error("multiplier finished outside a multiply state");

  a_search_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> ((step != '0) && (step <= STEP_W'(SEARCH_MAX))))
    else $error("search step out of range");

  a_bytes_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_BYTE) |-> ((bytes_left != '0) && (bytes_left <= NB_W'(5))))
    else $error("code byte state with bad byte count");

endmodule

// ===== rtl/bae_mul.sv =====
`timescale 1ns / 1ps
// Iterative multiplier: (a * b) >> FRAC_BITS, truncated, one 8-bit digit of b per cycle.
// Depends on bae_pkg; used by block_arithmetic_encoder.
module bae_mul #(
  parameter int FRAC_BITS = bae_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [FRAC_BITS:0]           a,
  input  logic [bae_pkg::BOUND_W-1:0]  b,
  output logic                         done,
  output logic [FRAC_BITS:0]           p
);

  localparam int WW   = FRAC_BITS + 1;
  localparam int PW   = WW + bae_pkg::BOUND_W;
  localparam int SR_W = bae_pkg::N_DIG * bae_pkg::DIG_BITS;
  localparam int PPW  = WW + bae_pkg::DIG_BITS;
  localparam int CW   = $clog2(bae_pkg::N_DIG + 1);

  logic [WW-1:0]                    a_q;
  logic [SR_W-1:0]                  b_sr;
  logic [PW-1:0]                    acc;
  logic [PW-1:0]                    acc_next;
  logic [CW-1:0]                    cnt;
  logic                             busy;
  logic [bae_pkg::DIG_BITS-1:0]     digit;
  logic [PPW-1:0]                   pp;

  assign digit    = b_sr[SR_W-1 -: bae_pkg::DIG_BITS];
  assign pp       = PPW'(a_q) * PPW'(digit);
  assign acc_next = (acc << bae_pkg::DIG_BITS) + PW'(pp);
  assign p        = WW'(acc >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(bae_pkg::N_DIG);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q  <= a;
      b_sr <= SR_W'(b);
      acc  <= '0;
    end else if (busy) begin
      acc  <= acc_next;
      b_sr <= b_sr << bae_pkg::DIG_BITS;
    end
  end

endmodule
